>>> hw/rtl/ufbs_pkg.sv
`default_nettype none
package ufbs_pkg;
  localparam int unsigned DivisorBits = 16;
  localparam int unsigned DivW = 48;
  localparam logic [26:0] CoreClockReset = 27'd100000000;
  localparam logic [23:0] FastBaud = 24'd1000000;

  // controller commands to the datapath
  typedef struct packed {
    logic start;     // clear best, load target
    logic level;     // load pclk for shift_q
    logic calc;      // start divisor division
    logic rate;      // unused; the datapath starts the rate division itself
    logic keep;      // compare and keep
    logic lvl_chk;   // unused; lvl_ok is driven without it
    logic [1:0] shift;
    logic [3:0] mul;
    logic [3:0] add;
  } ufbs_cmd_t;

  typedef struct packed {
    logic busy;      // calc issued or division sequence running
    logic skip;      // divisor overflow
    logic stop;      // early stop after keep
    logic lvl_ok;    // level error below limit
  } ufbs_sts_t;
endpackage
`default_nettype wire

>>> hw/rtl/ufbs_if.sv
`default_nettype none
interface ufbs_in_if;
  logic valid;
  logic ready;
  logic [23:0] baud_req;
  modport source (output valid, output baud_req, input ready);
  modport sink (input valid, input baud_req, output ready);
endinterface

interface ufbs_out_if;
  logic valid;
  logic ready;
  logic [23:0] achieved_baud;
  logic [1:0] prescale_shift;
  logic [15:0] divisor;
  logic [3:0] multiplier;
  logic [3:0] fraction_add;
  logic [8:0] iterations;
  modport source (output valid, output achieved_baud, output prescale_shift,
    output divisor, output multiplier, output fraction_add, output iterations,
    input ready);
  modport sink (input valid, input achieved_baud, input prescale_shift,
    input divisor, input multiplier, input fraction_add, input iterations,
    output ready);
endinterface

interface ufbs_cfg_if;
  logic valid;
  logic ready;
  logic [26:0] data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

>>> hw/rtl/ufbs_div.sv
`default_nettype none
// restoring divider, one quotient bit per cycle
module ufbs_div import ufbs_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic start_i,
  input  wire logic [DivW-1:0] num_i,
  input  wire logic [DivW-1:0] den_i,
  output logic busy_o,
  output logic [DivW-1:0] quo_o
);
  logic [DivW-1:0] quo_q, quo_d, rem_q, rem_d, den_q, den_d;
  logic [5:0] cnt_q, cnt_d;
  logic [DivW:0] trial;

  always_comb begin
    quo_d = quo_q;
    rem_d = rem_q;
    den_d = den_q;
    cnt_d = cnt_q;
    trial = {rem_q, quo_q[DivW-1]} - {1'b0, den_q};
    if (start_i) begin
      quo_d = num_i;
      rem_d = '0;
      den_d = den_i;
      cnt_d = 6'(DivW);
    end else if (cnt_q != 6'd0) begin
      cnt_d = cnt_q - 6'd1;
      if (!trial[DivW]) begin
        rem_d = trial[DivW-1:0];
        quo_d = {quo_q[DivW-2:0], 1'b1};
      end else begin
        rem_d = {rem_q[DivW-2:0], quo_q[DivW-1]};
        quo_d = {quo_q[DivW-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    den_q <= den_d;
  end

  assign busy_o = (cnt_q != 6'd0);
  assign quo_o = quo_q;
endmodule
`default_nettype wire

>>> hw/rtl/ufbs_datapath.sv
`default_nettype none
// candidate arithmetic, best tracking
module ufbs_datapath import ufbs_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic [26:0] core_clock_i,
  input  wire logic [23:0] target_i,
  input  ufbs_cmd_t cmd_i,
  output ufbs_sts_t sts_o,
  output logic [23:0] best_rate_o,
  output logic [1:0] best_shift_o,
  output logic [15:0] best_div_o,
  output logic [3:0] best_mul_o,
  output logic [3:0] best_add_o
);
  logic [23:0] t_q;
  logic [26:0] pclk_q;
  logic [31:0] best_rate_q, rate_q;
  logic [1:0] best_shift_q;
  logic [15:0] best_div_q, dl_q;
  logic [3:0] best_mul_q, best_add_q;
  logic [DivW-1:0] num, den, quo;
  logic [1:0] phase_q;  // 0 idle, 1 divisor, 2 dx fraction, 3 rate
  logic div_start, div_busy;
  logic [DivW-1:0] dl_full;
  logic [15:0] dl_clamp;
  logic [31:0] dx_base, err_new, err_best;
  logic [47:0] err_fine, err_lvl;

  ufbs_div u_div (.clk_i, .rst_ni, .start_i(div_start), .num_i(num), .den_i(den),
    .busy_o(div_busy), .quo_o(quo));

  // rounded divisor and clamp
  assign dl_full = (quo + 48'd1) >> 1;
  always_comb begin
    dl_clamp = dl_full[15:0];
    if (dl_clamp == 16'd0) dl_clamp = 16'd1;
    if (cmd_i.add != 4'd0 && dl_clamp < 16'd2) dl_clamp = 16'd2;
  end
  assign dx_base = {4'd0, dl_q, 12'd0};

  // division operand selection
  always_comb begin
    num = '0;
    den = '1;
    div_start = 1'b0;
    if (cmd_i.calc) begin
      num = 48'(pclk_q) * 48'(cmd_i.mul) * 48'd2;
      den = 48'(t_q) * 48'd16 * 48'(5'(cmd_i.add) + 5'(cmd_i.mul));
      div_start = 1'b1;
    end else if (phase_q == 2'd1 && !div_busy) begin
      // divisor is latched this cycle, so take it straight from the clamp
      num = 48'({dl_clamp, 12'd0}) * 48'(cmd_i.add);
      den = 48'(cmd_i.mul);
      div_start = 1'b1;
    end else if (phase_q == 2'd2 && !div_busy) begin
      num = 48'({pclk_q, 5'd0});
      den = 48'(dx_base) + quo;
      div_start = 1'b1;
    end
  end

  function automatic logic [31:0] absd(input logic [31:0] x, input logic [31:0] y);
    return (x >= y) ? x - y : y - x;
  endfunction

  assign err_new = absd(rate_q, {8'd0, t_q});
  assign err_best = absd(best_rate_q, {8'd0, t_q});
  assign err_fine = 48'(err_new) * 48'd1536;
  assign err_lvl = 48'(err_best) * 48'd200;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= 2'd0;
    end else if (cmd_i.calc) begin
      phase_q <= 2'd1;
    end else if (phase_q == 2'd1 && !div_busy) begin
      phase_q <= 2'd2;
    end else if (phase_q == 2'd2 && !div_busy) begin
      phase_q <= 2'd3;
    end else if (phase_q == 2'd3 && !div_busy) begin
      phase_q <= 2'd0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      t_q <= target_i;
      best_rate_q <= '0;
      best_shift_q <= '0;
      best_div_q <= '0;
      best_mul_q <= '0;
      best_add_q <= '0;
    end
    if (cmd_i.level) pclk_q <= core_clock_i >> cmd_i.shift;
    // latch divisor once the first division lands
    if (phase_q == 2'd1 && !div_busy) dl_q <= dl_clamp;
    if (phase_q == 2'd3 && !div_busy) rate_q <= {quo[28:0], 3'd0};
    if (cmd_i.keep && err_new < err_best) begin
      best_rate_q <= rate_q;
      best_shift_q <= cmd_i.shift;
      best_div_q <= dl_q;
      best_mul_q <= cmd_i.mul;
      best_add_q <= cmd_i.add;
    end
  end

  assign sts_o.busy = (phase_q != 2'd0) || cmd_i.calc;
  assign sts_o.skip = (phase_q == 2'd1) && !div_busy &&
                      (dl_full > 48'((1 << DivisorBits) - 1));
  assign sts_o.stop = (err_new < err_best) &&
                      ((err_new == 32'd0) || (err_fine < 48'(t_q)));
  assign sts_o.lvl_ok = err_lvl < 48'(t_q);
  assign best_rate_o = best_rate_q[23:0];
  assign best_shift_o = best_shift_q;
  assign best_div_o = best_div_q;
  assign best_mul_o = best_mul_q;
  assign best_add_o = best_add_q;
endmodule
`default_nettype wire

>>> hw/rtl/ufbs_ctrl.sv
`default_nettype none
// search sequencer over shift, multiplier and adder
module ufbs_ctrl import ufbs_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  input  wire logic [23:0] target_i,
  output logic in_ready_o,
  output logic out_valid_o,
  input  wire logic out_ready_i,
  input  ufbs_sts_t sts_i,
  output ufbs_cmd_t cmd_o,
  output logic [8:0] iter_o
);
  localparam logic [2:0] SIdle = 3'd0, SLevel = 3'd1, SCalc = 3'd2, SWait = 3'd3,
    SKeep = 3'd4, SNext = 3'd5, SLvl = 3'd6, SDone = 3'd7;
  logic [2:0] state_q, state_d;
  logic [1:0] shift_q, shift_d;
  logic [3:0] mul_q, mul_d, add_q, add_d;
  logic [8:0] iter_q, iter_d;
  logic skip_q, skip_d;

  always_comb begin
    state_d = state_q;
    shift_d = shift_q;
    mul_d = mul_q;
    add_d = add_q;
    iter_d = iter_q;
    skip_d = skip_q;
    cmd_o = '0;
    cmd_o.shift = shift_q;
    cmd_o.mul = mul_q;
    cmd_o.add = add_q;
    case (state_q)
      SIdle: begin
        if (in_valid_i) begin
          cmd_o.start = 1'b1;
          iter_d = '0;
          shift_d = (target_i < FastBaud) ? 2'd3 : 2'd1;
          state_d = (target_i == 24'd0) ? SDone : SLevel;
        end
      end
      SLevel: begin
        cmd_o.level = 1'b1;
        mul_d = 4'd1;
        add_d = 4'd0;
        state_d = SCalc;
      end
      SCalc: begin
        cmd_o.calc = 1'b1;
        iter_d = iter_q + 9'd1;
        skip_d = 1'b0;
        state_d = SWait;
      end
      SWait: begin
        if (sts_i.skip) skip_d = 1'b1;
        if (!sts_i.busy) state_d = skip_q ? SNext : SKeep;
      end
      SKeep: begin
        cmd_o.keep = 1'b1;
        state_d = sts_i.stop ? SDone : SNext;
      end
      SNext: begin
        if (add_q + 4'd1 < mul_q) begin
          add_d = add_q + 4'd1;
          state_d = SCalc;
        end else if (mul_q != 4'd15) begin
          mul_d = mul_q + 4'd1;
          add_d = 4'd0;
          state_d = SCalc;
        end else begin
          state_d = SLvl;
        end
      end
      SLvl: begin
        if (sts_i.lvl_ok || shift_q == 2'd0) begin
          state_d = SDone;
        end else begin
          shift_d = shift_q - 2'd1;
          state_d = SLevel;
        end
      end
      SDone: begin
        if (out_ready_i) state_d = SIdle;
      end
      default: state_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle;
      shift_q <= '0;
      mul_q <= '0;
      add_q <= '0;
      iter_q <= '0;
      skip_q <= 1'b0;
    end else begin
      state_q <= state_d;
      shift_q <= shift_d;
      mul_q <= mul_d;
      add_q <= add_d;
      iter_q <= iter_d;
      skip_q <= skip_d;
    end
  end

  assign in_ready_o = (state_q == SIdle);
  assign out_valid_o = (state_q == SDone);
  assign iter_o = iter_q;
endmodule
`default_nettype wire

>>> hw/rtl/uart_fractional_baud_search.sv
`default_nettype none
// Fractional baud divider search. Each requested-rate item yields one result
// with the closest prescale shift, divisor, multiplier and adder. Every
// candidate runs three 48-bit serial divisions on one shared divider before
// its step and, unless the divisor overflows, its compare; an item runs at
// most 480 candidates. core_clock is to be written on the cfg channel only
// while the block is idle; the block does not enforce this. core_clock
// resets to 100 MHz.
module uart_fractional_baud_search import ufbs_pkg::*; (
  input wire logic clk_i,
  input wire logic rst_ni,
  ufbs_cfg_if.sink cfg,
  ufbs_in_if.sink in_ch,
  ufbs_out_if.source out_ch
);
  logic [26:0] core_clock_q;
  ufbs_cmd_t cmd;
  ufbs_sts_t sts;

  // core clock register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      core_clock_q <= CoreClockReset;
    end else if (cfg.valid) begin
      core_clock_q <= cfg.data;
    end
  end
  assign cfg.ready = 1'b1;

  ufbs_ctrl u_ctrl (.clk_i, .rst_ni, .in_valid_i(in_ch.valid), .target_i(in_ch.baud_req),
    .in_ready_o(in_ch.ready), .out_valid_o(out_ch.valid), .out_ready_i(out_ch.ready),
    .sts_i(sts), .cmd_o(cmd), .iter_o(out_ch.iterations));

  ufbs_datapath u_dp (.clk_i, .rst_ni, .core_clock_i(core_clock_q),
    .target_i(in_ch.baud_req), .cmd_i(cmd), .sts_o(sts),
    .best_rate_o(out_ch.achieved_baud), .best_shift_o(out_ch.prescale_shift),
    .best_div_o(out_ch.divisor), .best_mul_o(out_ch.multiplier),
    .best_add_o(out_ch.fraction_add));
endmodule
`default_nettype wire

>>> bench/uart_fractional_baud_search_tb.sv
`timescale 1ns / 1ps
module uart_fractional_baud_search_tb import ufbs_pkg::*; ();

  typedef struct {
    logic [23:0] achieved_baud;
    logic [1:0]  prescale_shift;
    logic [15:0] divisor;
    logic [3:0]  multiplier;
    logic [3:0]  fraction_add;
    logic [8:0]  iterations;
  } baud_setting_t;

  logic clk_i;
  logic rst_ni;

  ufbs_cfg_if cfg_if();
  ufbs_in_if  in_if();
  ufbs_out_if out_if();

  uart_fractional_baud_search i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg    (cfg_if),
    .in_ch  (in_if),
    .out_ch (out_if)
  );

  logic [23:0]   pending_targets[$];
  baud_setting_t expected_settings[$];
  logic [26:0]   core_clock_q;
  int            error_count;
  int            in_gap_left;
  int            out_gap_left;
  int            hold_left;
  int            results_seen;
  bit            hold_done;
  bit            calm;

  // clock
  always begin
    clk_i = 1'b1;
    #1;
    clk_i = 1'b0;
    #1;
  end

  // best divider setting for one requested rate
  function automatic baud_setting_t search_baud(logic [23:0] target, logic [26:0] clk_hz);
    baud_setting_t best;
    logic [63:0] t, pclk, dl, dx, rate, best_rate, d_new, d_best;
    int          shift;
    int          iter;
    bit          done;
    best = '{default: '0};
    t = {40'd0, target};
    best_rate = 0;
    iter = 0;
    done = 0;
    if (t != 0) begin
      for (shift = (t < 64'd1000000) ? 3 : 1; shift >= 0 && !done; shift--) begin
        pclk = {37'd0, clk_hz} >> shift;
        for (int m = 1; m < 16 && !done; m++) begin
          for (int a = 0; a < m && !done; a++) begin
            iter++;
            dl = ((2 * m * pclk) / (16 * t * (a + m)) + 1) / 2;
            if (dl > 64'd65535) continue;
            if (dl == 0) dl = 1;
            if (a > 0 && dl < 2) dl = 2;
            dx = dl * 4096 + (dl * 4096 * a) / m;
            rate = ((pclk * 32) / dx) * 8;
            d_new = (rate >= t) ? rate - t : t - rate;
            d_best = (best_rate >= t) ? best_rate - t : t - best_rate;
            if (d_new < d_best) begin
              best_rate = rate;
              best.prescale_shift = shift[1:0];
              best.divisor = dl[15:0];
              best.multiplier = m[3:0];
              best.fraction_add = a[3:0];
              if (rate == t) done = 1;
              else if (d_new * 1536 / t < 1) done = 1;
            end
          end
        end
        d_best = (best_rate >= t) ? best_rate - t : t - best_rate;
        if (!done && d_best * 200 / t < 1) done = 1;
      end
    end
    best.achieved_baud = best_rate[23:0];
    best.iterations = iter[8:0];
    return best;
  endfunction

  // mostly short gaps, a few long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(99);
    if (calm || r < 65) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(20, 200);
  endfunction

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %0d expected %0d", what, got, want);
    error_count++;
  endtask

  // item driver
  always @(posedge clk_i or negedge rst_ni) begin : drv
    int g;
    bit take;
    if (!rst_ni) begin
      in_if.valid <= 1'b0;
      in_if.baud_req <= '0;
      in_gap_left <= 0;
    end else begin
      take = in_if.valid && in_if.ready;
      if (take) expected_settings.push_back(search_baud(in_if.baud_req, core_clock_q));
      if (!in_if.valid || take) begin
        g = take ? pick_gap() : in_gap_left;
        if (g == 0 && pending_targets.size() > 0) begin
          in_if.valid <= 1'b1;
          in_if.baud_req <= pending_targets.pop_front();
          in_gap_left <= 0;
        end else begin
          in_if.valid <= 1'b0;
          in_gap_left <= (g > 0) ? g - 1 : 0;
        end
      end
    end
  end

  // one long hold-off so the block backs up its input
  always @(posedge clk_i or negedge rst_ni) begin : hold_ctl
    if (!rst_ni) begin
      hold_left <= 0;
      hold_done <= 0;
    end else if (!hold_done && results_seen == 30) begin
      hold_done <= 1;
      hold_left <= 100000;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // result monitor and ready control
  always @(posedge clk_i or negedge rst_ni) begin : mon
    baud_setting_t want;
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
      out_gap_left <= 0;
      results_seen <= 0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        results_seen <= results_seen + 1;
        if (expected_settings.size() == 0) begin
          report("unexpected item", out_if.achieved_baud, 0);
        end else begin
          want = expected_settings.pop_front();
          if (out_if.achieved_baud !== want.achieved_baud)
            report("achieved_baud", out_if.achieved_baud, want.achieved_baud);
          if (out_if.prescale_shift !== want.prescale_shift)
            report("prescale_shift", out_if.prescale_shift, want.prescale_shift);
          if (out_if.divisor !== want.divisor)
            report("divisor", out_if.divisor, want.divisor);
          if (out_if.multiplier !== want.multiplier)
            report("multiplier", out_if.multiplier, want.multiplier);
          if (out_if.fraction_add !== want.fraction_add)
            report("fraction_add", out_if.fraction_add, want.fraction_add);
          if (out_if.iterations !== want.iterations)
            report("iterations", out_if.iterations, want.iterations);
        end
      end
      // hold-off and random gaps on ready
      if (hold_left > 0 || (!hold_done && results_seen == 30)) begin
        out_if.ready <= 1'b0;
      end else if (out_gap_left > 0) begin
        out_gap_left <= out_gap_left - 1;
        out_if.ready <= 1'b0;
      end else begin
        out_gap_left <= pick_gap();
        out_if.ready <= 1'b1;
      end
    end
  end

  task automatic wait_drained();
    while (pending_targets.size() > 0 || in_if.valid || expected_settings.size() > 0)
      @(negedge clk_i);
    repeat (100) @(posedge clk_i);
  endtask

  task automatic write_core_clock(logic [26:0] value);
    @(posedge clk_i);
    cfg_if.valid <= 1'b1;
    cfg_if.data <= value;
    do @(posedge clk_i); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    core_clock_q = value;
  endtask

  function automatic logic [23:0] random_target();
    logic [23:0] common_rates[12] = '{300, 1200, 2400, 9600, 19200, 38400, 57600,
                                      115200, 230400, 460800, 921600, 1000000};
    int r;
    r = $urandom_range(99);
    if (r < 55) return common_rates[$urandom_range(11)];
    if (r < 85) return 24'($urandom_range(1, 8388608));
    return 24'($urandom());
  endfunction

  // limit
  initial begin
    #200000000;
    $display("Some tests failed");
    $finish;
  end

  // stimulus
  initial begin
    rst_ni = 1'b0;
    cfg_if.valid = 1'b0;
    cfg_if.data = '0;
    in_if.valid = 1'b0;
    in_if.baud_req = '0;
    out_if.ready = 1'b0;
    core_clock_q = CoreClockReset;
    error_count = 0;
    calm = 1;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset clock: extremes, zero target, fast boundary
    pending_targets = '{24'd1, 24'd0, 24'hFFFFFF, 24'd8388608, 24'd9600, 24'd115200,
                        24'd999999, 24'd1000000, 24'd3000000, 24'h555555, 24'hAAAAAA};
    wait_drained();

    // largest core clock
    calm = 0;
    write_core_clock(27'h7FFFFFF);
    pending_targets = '{24'd115200, 24'd8388608, 24'd250000, 24'd31250};
    wait_drained();

    // slowest clock: nothing fits
    write_core_clock(27'd1);
    pending_targets = '{24'd9600, 24'd1000000};
    wait_drained();

    // zero clock
    write_core_clock(27'd0);
    pending_targets = '{24'd115200, 24'd1};
    wait_drained();

    // random clocks and rates, with one full pause midway
    write_core_clock(27'($urandom_range(12000000, 134217727)));
    for (int i = 0; i < 30; i++) pending_targets.push_back(random_target());
    wait_drained();
    for (int i = 0; i < 30; i++) pending_targets.push_back(random_target());
    wait_drained();
    write_core_clock(27'($urandom()));
    for (int i = 0; i < 20; i++) pending_targets.push_back(random_target());
    wait_drained();

    if (expected_settings.size() != 0) report("leftover items", expected_settings.size(), 0);
    if (error_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end
endmodule
